/* rtl/core/qnco_pkg.sv */
// ----------------------------------------------------------------------------
// qnco_pkg
// Shared constants, register codes, lane control type and the sine table
// generator for the quadrature NCO.
// ----------------------------------------------------------------------------
package qnco_pkg;

	localparam int TABLE_ENTRIES_DEF       = 512;
	localparam int SAMPLE_WIDTH_DEF        = 24;
	localparam int PHASE_FRACTION_BITS_DEF = 23;
	localparam int QUEUE_DEPTH             = 2;

	localparam int PHASE_WIDTH     = 32;
	localparam int AMP_WIDTH       = 16;
	localparam int AMP_FRAC_BITS   = 14;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 32;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIMPLE_MODE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_INC   = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_OFFSET  = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AMPLITUDE   = 2'd3;

	localparam logic                   SIMPLE_MODE_RST = 1'b1;
	localparam logic [PHASE_WIDTH-1:0] PHASE_INC_RST   = 32'h0000_0000;
	localparam logic [PHASE_WIDTH-1:0] COS_OFFSET_RST  = 32'h4000_0000;
	localparam logic [AMP_WIDTH-1:0]   AMPLITUDE_RST   = 16'h4000;

	// pi in unsigned Q4.60
	localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

	typedef struct packed {
		logic look;
		logic mul;
		logic intp;
		logic sat;
	} lane_ctl_t;

	// Q4.60 product, truncated
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// unsigned quotient by shift and subtract, elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] rem;
		int          i;
		q   = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Table magnitude for an angle x in [0, pi] (Q4.60), elaboration only.
	function automatic logic [31:0] rom_mag(input logic [63:0] x_in, input int sw);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		logic [63:0] cap;
		logic [63:0] div;
		int k;
		x = x_in;
		if (x > (PI_Q60 >> 1)) begin
			x = PI_Q60 - x;
		end
		x2   = mul_q60(x, x);
		term = x;
		sum  = x;
		for (k = 1; k <= 30; k++) begin
			if (term != 64'd0) begin
				div  = 64'(2 * k * (2 * k + 1));
				term = div_u64(mul_q60(term, x2), div);
				if (k[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		v   = ((sum >> (60 - sw)) + 64'd1) >> 1;
		cap = (64'd1 << (sw - 1)) - 64'd1;
		if (v > cap) begin
			v = cap;
		end
		return v[31:0];
	endfunction

endpackage

/* rtl/core/quadrature_sine_cosine_nco_core.sv */
// ----------------------------------------------------------------------------
// quadrature_sine_cosine_nco_core
// An accepted tick beat passes the front register, the queue and the lane
// lookup, multiply, interpolate and saturate registers to out_valid. The next
// lookup overlaps the saturate step unless out_valid is held; ticks enter every
// cycle until the 2-entry queue fills. Tick beats with sample_tick low are taken
// and dropped. Reset: asynchronous, clears accumulator, queue and sequencer and
// loads the register defaults; the sine table is constant and needs no init pass.
// ----------------------------------------------------------------------------
module quadrature_sine_cosine_nco_core import qnco_pkg::*; #(
	parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
	parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
	parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           sample_tick,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sine_sample,
	output logic signed [SAMPLE_WIDTH-1:0] cosine_sample
);

	localparam int IDXW = $clog2(TABLE_ENTRIES);
	localparam int QW   = 2 * IDXW + 2 * PHASE_FRACTION_BITS + 1;

	logic                        simple_mode_q;
	logic [PHASE_WIDTH-1:0]      phase_increment_q;
	logic [PHASE_WIDTH-1:0]      cos_phase_offset_q;
	logic signed [AMP_WIDTH-1:0] amplitude_q;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			simple_mode_q      <= SIMPLE_MODE_RST;
			phase_increment_q  <= PHASE_INC_RST;
			cos_phase_offset_q <= COS_OFFSET_RST;
			amplitude_q        <= AMPLITUDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIMPLE_MODE: simple_mode_q      <= cfg_data[0];
				REG_PHASE_INC:   phase_increment_q  <= cfg_data[PHASE_WIDTH-1:0];
				REG_COS_OFFSET:  cos_phase_offset_q <= cfg_data[PHASE_WIDTH-1:0];
				REG_AMPLITUDE:   amplitude_q        <= cfg_data[AMP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	qnco_front #(
		.TABLE_ENTRIES       (TABLE_ENTRIES),
		.PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample_tick      (sample_tick),
		.simple_mode      (simple_mode_q),
		.phase_increment  (phase_increment_q),
		.cos_phase_offset (cos_phase_offset_q),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_data           (q_wdata)
	);

	qnco_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	qnco_back #(
		.TABLE_ENTRIES       (TABLE_ENTRIES),
		.SAMPLE_WIDTH        (SAMPLE_WIDTH),
		.PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_head),
		.q_pop         (q_pop),
		.amplitude     (amplitude_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sine_sample   (sine_sample),
		.cosine_sample (cosine_sample)
	);

	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full)
		else $error("input stalled with queue space left");

	a_tick_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && sample_tick |=> q_push || q_full)
		else $error("accepted tick not pushed nor held for a full queue");

	a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule

/* rtl/core/qnco_fifo.sv */
// ----------------------------------------------------------------------------
// qnco_fifo
// Small register queue between the phase front end and the sample back end.
// ----------------------------------------------------------------------------
module qnco_fifo import qnco_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/qnco_front.sv */
// ----------------------------------------------------------------------------
// qnco_front
// Takes tick beats, advances the phase accumulator and queues the sine and
// cosine table positions for the back end.
// ----------------------------------------------------------------------------
module qnco_front import qnco_pkg::*; #(
	parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
	parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF,
	localparam int IDXW = $clog2(TABLE_ENTRIES),
	localparam int QW   = 2 * IDXW + 2 * PHASE_FRACTION_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   sample_tick,
	input  logic                   simple_mode,
	input  logic [PHASE_WIDTH-1:0] phase_increment,
	input  logic [PHASE_WIDTH-1:0] cos_phase_offset,
	input  logic                   q_full,
	output logic                   q_push,
	output logic [QW-1:0]          q_data
);

	localparam int F = PHASE_FRACTION_BITS;
	localparam logic [IDXW-1:0] QUARTER = IDXW'(TABLE_ENTRIES / 4);

	logic [PHASE_WIDTH-1:0]   acc_q;
	logic                     pend_s1;
	logic                     accept;
	logic [PHASE_WIDTH-1:0]   cos_phase;
	logic [2*PHASE_WIDTH-1:0] sin_ext;
	logic [2*PHASE_WIDTH-1:0] cos_ext;
	logic [IDXW-1:0]          sin_idx;
	logic [IDXW-1:0]          cos_idx;
	logic [F-1:0]             sin_frac;
	logic [F-1:0]             cos_frac;

	assign in_ready = !pend_s1 || !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = pend_s1 && !q_full;

	always_comb begin
		cos_phase = acc_q + cos_phase_offset;
		sin_ext   = {{PHASE_WIDTH{1'b0}}, acc_q} >> F;
		cos_ext   = {{PHASE_WIDTH{1'b0}}, cos_phase} >> F;
		sin_idx   = sin_ext[IDXW-1:0];
		sin_frac  = acc_q[F-1:0];
		if (simple_mode) begin
			cos_idx  = sin_idx + QUARTER;
			cos_frac = sin_frac;
		end else begin
			cos_idx  = cos_ext[IDXW-1:0];
			cos_frac = cos_phase[F-1:0];
		end
		q_data = {simple_mode, sin_idx, sin_frac, cos_idx, cos_frac};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (accept && sample_tick) begin
				acc_q   <= acc_q + phase_increment;
				pend_s1 <= 1'b1;
			end else if (q_push) begin
				pend_s1 <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/qnco_lane.sv */
// ----------------------------------------------------------------------------
// qnco_lane
// One output lane: half-wave sine table read, linear interpolation,
// amplitude scaling with rounding and saturation, skipped in simple mode.
// ----------------------------------------------------------------------------
module qnco_lane import qnco_pkg::*; #(
	parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
	parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
	parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF,
	localparam int IDXW = $clog2(TABLE_ENTRIES)
) (
	input  logic                           clk,
	input  lane_ctl_t                      ctl,
	input  logic [IDXW-1:0]                idx,
	input  logic [PHASE_FRACTION_BITS-1:0] frac,
	input  logic                           simple_mode,
	input  logic signed [AMP_WIDTH-1:0]    amplitude,
	output logic signed [SAMPLE_WIDTH-1:0] sample
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int F     = PHASE_FRACTION_BITS;
	localparam int HALF  = TABLE_ENTRIES / 2;
	localparam int HIDXW = IDXW - 1;
	localparam int PW    = SW + AMP_WIDTH;
	localparam int RW    = PW + 1 - AMP_FRAC_BITS;

	localparam logic [SW+F:0]   RHALF   = (SW + F + 1)'(1) << (F - 1);
	localparam logic [PW:0]     AROUND  = (PW + 1)'(1) << (AMP_FRAC_BITS - 1);
	localparam logic [SW-1:0]   SMAX    = {1'b0, {(SW - 1){1'b1}}};
	localparam logic [SW-1:0]   SMIN    = {1'b1, {(SW - 1){1'b0}}};
	localparam logic [RW-1:0]   POS_LIM = RW'(SMAX);
	localparam logic [RW-1:0]   NEG_LIM = RW'(SMIN);

	wire [HALF-1:0][SW-2:0] half_tab;

	for (genvar j = 0; j < HALF; j++) begin : g_tab
		localparam logic [63:0] XJ = (PI_Q60 / TABLE_ENTRIES) * (2 * j)
			+ ((PI_Q60 % TABLE_ENTRIES) * (2 * j)) / TABLE_ENTRIES;
		localparam logic [31:0] MAG = rom_mag(XJ, SAMPLE_WIDTH);
		assign half_tab[j] = MAG[SW-2:0];
	end

	// odd symmetry about the half-way entry; the end entries are both zero
	function automatic logic [SW-1:0] tab_read(input logic [HALF-1:0][SW-2:0] t,
			input logic [IDXW-1:0] m);
		logic [IDXW-1:0]  m_neg;
		logic             neg;
		logic [HIDXW-1:0] hidx;
		logic [SW-1:0]    mag;
		m_neg = ~m + IDXW'(1);
		neg   = m[IDXW-1] && (m[IDXW-2:0] != '0);
		hidx  = neg ? m_neg[HIDXW-1:0] : m[HIDXW-1:0];
		mag   = {1'b0, t[hidx]};
		return neg ? (~mag + SW'(1)) : mag;
	endfunction

	logic signed [SW-1:0] a_s1;
	logic signed [SW-1:0] b_s1;
	logic [F-1:0]         frac_s1;
	logic                 simple_s1;
	logic signed [SW-1:0] a_s2;
	logic [SW+F-1:0]      prod_s2;
	logic                 neg_s2;
	logic                 simple_s2;
	logic signed [SW-1:0] v_s3;
	logic signed [PW-1:0] p_s3;
	logic                 simple_s3;

	logic [SW:0]          diff;
	logic [SW:0]          diff_neg;
	logic [SW-1:0]        diff_mag;
	logic [SW+F:0]        rsum;
	logic [SW-1:0]        r;
	logic [SW:0]          v_wide;
	logic signed [SW-1:0] interp;
	logic signed [PW-1:0] scaled;
	logic [PW-1:0]        p_neg;
	logic [PW-1:0]        p_mag;
	logic [PW:0]          p_rnd;
	logic [RW-1:0]        r2;
	logic [SW-1:0]        r2_low;
	logic [SW-1:0]        sat_val;

	always_comb begin
		diff     = {b_s1[SW-1], b_s1} - {a_s1[SW-1], a_s1};
		diff_neg = ~diff + (SW + 1)'(1);
		diff_mag = diff[SW] ? diff_neg[SW-1:0] : diff[SW-1:0];

		rsum = {1'b0, prod_s2} + RHALF;
		r    = rsum[F +: SW];
		if (neg_s2) begin
			v_wide = {a_s2[SW-1], a_s2} - {1'b0, r};
		end else begin
			v_wide = {a_s2[SW-1], a_s2} + {1'b0, r};
		end
		interp = v_wide[SW-1:0];
		scaled = PW'(interp) * PW'(amplitude);

		p_neg  = ~p_s3 + PW'(1);
		p_mag  = p_s3[PW-1] ? p_neg : p_s3;
		p_rnd  = {1'b0, p_mag} + AROUND;
		r2     = p_rnd[AMP_FRAC_BITS +: RW];
		r2_low = r2[SW-1:0];
		if (simple_s3) begin
			sat_val = v_s3;
		end else if (p_s3[PW-1]) begin
			sat_val = (r2 > NEG_LIM) ? SMIN : (~r2_low + SW'(1));
		end else begin
			sat_val = (r2 > POS_LIM) ? SMAX : r2_low;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.look) begin
			a_s1      <= tab_read(half_tab, idx);
			b_s1      <= tab_read(half_tab, idx + IDXW'(1));
			frac_s1   <= frac;
			simple_s1 <= simple_mode;
		end
		if (ctl.mul) begin
			a_s2      <= a_s1;
			neg_s2    <= diff[SW];
			prod_s2   <= (SW + F)'(diff_mag) * (SW + F)'(frac_s1);
			simple_s2 <= simple_s1;
		end
		if (ctl.intp) begin
			v_s3      <= interp;
			p_s3      <= scaled;
			simple_s3 <= simple_s2;
		end
		if (ctl.sat) begin
			sample <= sat_val;
		end
	end

endmodule

/* rtl/core/qnco_back.sv */
// ----------------------------------------------------------------------------
// qnco_back
// Pops queued phase positions, steps the sine and cosine lanes through
// lookup, multiply, interpolate and saturate, and holds the output beat.
// ----------------------------------------------------------------------------
module qnco_back import qnco_pkg::*; #(
	parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
	parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
	parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF,
	localparam int IDXW = $clog2(TABLE_ENTRIES),
	localparam int QW   = 2 * IDXW + 2 * PHASE_FRACTION_BITS + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  logic [QW-1:0]                  q_data,
	output logic                           q_pop,
	input  logic signed [AMP_WIDTH-1:0]    amplitude,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sine_sample,
	output logic signed [SAMPLE_WIDTH-1:0] cosine_sample
);

	localparam int F = PHASE_FRACTION_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_INT  = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	logic [1:0]      state_q;
	logic [1:0]      state_nxt;
	logic            out_valid_q;
	logic            sat_fire;
	logic            look_fire;
	lane_ctl_t       ctl;
	logic            simple;
	logic [IDXW-1:0] sin_idx;
	logic [IDXW-1:0] cos_idx;
	logic [F-1:0]    sin_frac;
	logic [F-1:0]    cos_frac;

	assign cos_frac = q_data[F-1:0];
	assign cos_idx  = q_data[F +: IDXW];
	assign sin_frac = q_data[F + IDXW +: F];
	assign sin_idx  = q_data[2 * F + IDXW +: IDXW];
	assign simple   = q_data[QW-1];

	assign sat_fire  = (state_q == ST_SAT) && (!out_valid_q || out_ready);
	assign look_fire = q_valid && ((state_q == ST_IDLE) || sat_fire);
	assign q_pop     = look_fire;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl.look = look_fire;
		ctl.mul  = (state_q == ST_MUL);
		ctl.intp = (state_q == ST_INT);
		ctl.sat  = sat_fire;
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: state_nxt = look_fire ? ST_MUL : ST_IDLE;
			ST_MUL:  state_nxt = ST_INT;
			ST_INT:  state_nxt = ST_SAT;
			ST_SAT:  state_nxt = look_fire ? ST_MUL : (sat_fire ? ST_IDLE : ST_SAT);
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (sat_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	qnco_lane #(
		.TABLE_ENTRIES       (TABLE_ENTRIES),
		.SAMPLE_WIDTH        (SAMPLE_WIDTH),
		.PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
	) u_sine_lane (
		.clk         (clk),
		.ctl         (ctl),
		.idx         (sin_idx),
		.frac        (sin_frac),
		.simple_mode (simple),
		.amplitude   (amplitude),
		.sample      (sine_sample)
	);

	qnco_lane #(
		.TABLE_ENTRIES       (TABLE_ENTRIES),
		.SAMPLE_WIDTH        (SAMPLE_WIDTH),
		.PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
	) u_cosine_lane (
		.clk         (clk),
		.ctl         (ctl),
		.idx         (cos_idx),
		.frac        (cos_frac),
		.simple_mode (simple),
		.amplitude   (amplitude),
		.sample      (cosine_sample)
	);

endmodule
